>>> rtl/bedm_pkg.sv
// ----------------------------------------------------------------------------
// bedm_pkg
// Shared codes, types and base decoding for the edit distance matcher.
// ----------------------------------------------------------------------------
package bedm_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_PATTERN = 2'd1,
    MODE_TEXT    = 2'd2,
    MODE_FINISH  = 2'd3
  } mode_t;

  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_ERROR_LIMIT    = 1'b1;

  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_A_LC = 8'h61;
  localparam logic [7:0] CHAR_C_LC = 8'h63;
  localparam logic [7:0] CHAR_G_LC = 8'h67;
  localparam logic [7:0] CHAR_T_LC = 8'h74;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam int unsigned BASES = 4;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } base_t;

  typedef struct packed {
    logic       valid;
    mode_t      mode;
    logic       found;
    logic [4:0] distance;
  } chain_op_t;

  function automatic base_t decode_base(input logic [7:0] sym);
    base_t b;
    b.ok   = 1'b1;
    b.code = BASE_A;
    case (sym)
      CHAR_A, CHAR_A_LC: b.code = BASE_A;
      CHAR_C, CHAR_C_LC: b.code = BASE_C;
      CHAR_G, CHAR_G_LC: b.code = BASE_G;
      CHAR_T, CHAR_T_LC: b.code = BASE_T;
      default:           b.ok   = 1'b0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/bedm_mask_store.sv
// ----------------------------------------------------------------------------
// bedm_mask_store
// Four per-base pattern masks; cleared to ones, bits knocked out by pattern
// characters, and the mask of a text base handed to the row chain.
// ----------------------------------------------------------------------------
module bedm_mask_store
  import bedm_pkg::*;
#(
  parameter int PATTERN_BITS = 256,
  localparam int IDX_W = $clog2(PATTERN_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  mode_t                   mode,
  input  base_t                   base,
  input  logic [7:0]              position,
  input  logic [IDX_W:0]          m_eff,
  input  logic [IDX_W-1:0]        m_last,
  output logic [PATTERN_BITS-1:0] mask
);

  logic [BASES-1:0][PATTERN_BITS-1:0] masks;
  logic                               pos_ok;
  logic [IDX_W-1:0]                   bit_idx;

  assign pos_ok  = 32'(position) < 32'(m_eff);
  assign bit_idx = IDX_W'(32'(m_last) - 32'(position));
  assign mask    = masks[base.code];

  always_ff @(posedge clk) begin
    if (rst) begin
      masks <= '1;
    end else if (en) begin
      if (mode == MODE_CLEAR) begin
        masks <= '1;
      end else if (mode == MODE_PATTERN && base.ok && pos_ok) begin
        masks[base.code][bit_idx] <= 1'b0;
      end
    end
  end

  a_clear_sets_ones: assert property (@(posedge clk) disable iff (rst)
    en && mode == MODE_CLEAR |=> &masks)
    else $error("pattern masks not all ones after clear");

endmodule

>>> rtl/bedm_cell.sv
// ----------------------------------------------------------------------------
// bedm_cell
// One error row of the chain. Applies each operation from the registered
// output of the row above, keeping the previous row value for the row below.
// ----------------------------------------------------------------------------
module bedm_cell
  import bedm_pkg::*;
#(
  parameter int PATTERN_BITS = 256,
  parameter int ROW          = 0,
  localparam int IDX_W = $clog2(PATTERN_BITS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    active,
  input  logic [IDX_W-1:0]        m_last,
  input  chain_op_t               op_in,
  input  logic [PATTERN_BITS-1:0] mask_in,
  input  logic [PATTERN_BITS-1:0] up_row,
  input  logic [PATTERN_BITS-1:0] up_prev,
  output chain_op_t               op_out,
  output logic [PATTERN_BITS-1:0] mask_out,
  output logic [PATTERN_BITS-1:0] row,
  output logic [PATTERN_BITS-1:0] prev
);

  localparam logic [PATTERN_BITS-1:0] CLEAR_ROW = {PATTERN_BITS{1'b1}} << ROW;

  logic [PATTERN_BITS-1:0] row_next;
  logic [PATTERN_BITS-1:0] match_term;
  logic [PATTERN_BITS-1:0] step;
  chain_op_t               op_fwd;

  assign match_term = (row << 1) | mask_in;

  if (ROW == 0) begin : g_first
    assign step = match_term;
  end else begin : g_rest
    assign step = up_prev & (up_prev << 1) & (up_row << 1) & match_term;
  end

  always_comb begin
    row_next = row;
    if (op_in.valid && op_in.mode == MODE_CLEAR) begin
      row_next = CLEAR_ROW;
    end else if (op_in.valid && op_in.mode == MODE_TEXT && active) begin
      row_next = step;
    end
  end

  always_comb begin
    op_fwd = op_in;
    if (op_in.valid && op_in.mode == MODE_FINISH && active && !op_in.found
        && !row[m_last]) begin
      op_fwd.found    = 1'b1;
      op_fwd.distance = 5'(ROW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= CLEAR_ROW;
      prev         <= CLEAR_ROW;
      op_out.valid <= 1'b0;
    end else if (advance) begin
      row      <= row_next;
      prev     <= row;
      op_out   <= op_fwd;
      mask_out <= mask_in;
    end
  end

  a_clear_row: assert property (@(posedge clk) disable iff (rst)
    advance && op_in.valid && op_in.mode == MODE_CLEAR |=> row == CLEAR_ROW)
    else $error("row not at cleared value after clear");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    advance && !(op_in.valid && (op_in.mode == MODE_CLEAR || op_in.mode == MODE_TEXT))
    |=> row == $past(row) && prev == $past(row))
    else $error("row changed without clear or text");

endmodule

>>> rtl/bitap_edit_distance_match.sv
// ----------------------------------------------------------------------------
// bitap_edit_distance_match
// Bit-parallel approximate DNA matcher: a chain of error-row cells.
// ----------------------------------------------------------------------------
// One item is taken every cycle unless the input stalls. Pattern characters
// and clears act on the base masks at once; clears, text bases and finish
// items then walk down a chain of MAX_ERRORS+1 cells, one error row per cell,
// each cell registering the item for the cell below, and a finish result is
// registered from the last cell. The input stalls only while a finish item
// has reached the end of the chain and the previous result is not yet taken.
module bitap_edit_distance_match
  import bedm_pkg::*;
#(
  parameter int PATTERN_BITS = 256,
  parameter int MAX_ERRORS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [8:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // symbol[7:0], position[15:8]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // distance[4:0], zero pad[7:5]
  output logic        m_tuser    // found[0]
);

  localparam int IDX_W = $clog2(PATTERN_BITS);
  localparam int K_W   = $clog2(MAX_ERRORS + 1);
  localparam int ROWS  = MAX_ERRORS + 1;

  logic [8:0]       pat_len;
  logic [4:0]       error_limit;
  logic [IDX_W:0]   m_eff;
  logic [IDX_W-1:0] m_last;
  logic [K_W-1:0]   k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len     <= 9'd1;
      error_limit <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PATTERN_LENGTH: pat_len     <= cfg_wdata;
        REG_ERROR_LIMIT:    error_limit <= cfg_wdata[4:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    if (pat_len == 9'd0) begin
      m_eff = (IDX_W + 1)'(1);
    end else if (32'(pat_len) > PATTERN_BITS) begin
      m_eff = (IDX_W + 1)'(PATTERN_BITS);
    end else begin
      m_eff = (IDX_W + 1)'(32'(pat_len));
    end
    m_last = IDX_W'(m_eff - 1'b1);
    if (32'(error_limit) > MAX_ERRORS) begin
      k_eff = K_W'(MAX_ERRORS);
    end else begin
      k_eff = K_W'(32'(error_limit));
    end
  end

  mode_t      in_mode;
  logic [7:0] in_symbol;
  logic [7:0] in_position;
  base_t      in_base;
  logic       accept;
  logic       advance;

  assign in_mode     = mode_t'(s_tuser);
  assign in_symbol   = s_tdata[7:0];
  assign in_position = s_tdata[15:8];
  assign in_base     = decode_base(in_symbol);
  assign s_tready    = advance;
  assign accept      = s_tvalid && advance;

  chain_op_t               ops   [0:ROWS];
  logic [PATTERN_BITS-1:0] masks [0:ROWS];
  logic [PATTERN_BITS-1:0] rows  [0:ROWS-1];
  logic [PATTERN_BITS-1:0] prevs [0:ROWS-1];

  bedm_mask_store #(
    .PATTERN_BITS(PATTERN_BITS)
  ) u_masks (
    .clk     (clk),
    .rst     (rst),
    .en      (accept),
    .mode    (in_mode),
    .base    (in_base),
    .position(in_position),
    .m_eff   (m_eff),
    .m_last  (m_last),
    .mask    (masks[0])
  );

  assign ops[0].valid    = accept && (in_mode == MODE_CLEAR || in_mode == MODE_FINISH
                           || (in_mode == MODE_TEXT && in_base.ok));
  assign ops[0].mode     = in_mode;
  assign ops[0].found    = 1'b0;
  assign ops[0].distance = 5'd0;

  for (genvar d = 0; d < ROWS; d++) begin : g_row
    logic                    active;
    logic [PATTERN_BITS-1:0] up_row;
    logic [PATTERN_BITS-1:0] up_prev;

    assign active = 32'(k_eff) >= d;

    if (d == 0) begin : g_top
      assign up_row  = '1;
      assign up_prev = '1;
    end else begin : g_link
      assign up_row  = rows[d-1];
      assign up_prev = prevs[d-1];
    end

    bedm_cell #(
      .PATTERN_BITS(PATTERN_BITS),
      .ROW         (d)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .active  (active),
      .m_last  (m_last),
      .op_in   (ops[d]),
      .mask_in (masks[d]),
      .up_row  (up_row),
      .up_prev (up_prev),
      .op_out  (ops[d+1]),
      .mask_out(masks[d+1]),
      .row     (rows[d]),
      .prev    (prevs[d])
    );
  end

  logic       last_finish;
  logic       out_found;
  logic [4:0] out_min;

  assign last_finish = ops[ROWS].valid && ops[ROWS].mode == MODE_FINISH;
  assign advance     = !(last_finish && m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && last_finish) begin
      m_tvalid  <= 1'b1;
      out_found <= ops[ROWS].found;
      out_min   <= ops[ROWS].distance;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {3'b000, out_min};
  assign m_tuser = out_found;

  a_stall_only_blocked: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready && last_finish)
    else $error("input stalled without a blocked result");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("distance non-zero on a not-found result");

endmodule

>>> test/bitap_edit_distance_match_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitap_edit_distance_match_test
// Self-checking bench for the approximate DNA matcher. A short directed table
// covers the register and field extremes and each kind of ignored input.
// Random pattern/text searches follow, mostly well formed, plus noise. Reports
// are scored against a bit-level predictor of masks and rows or a table value.
// ----------------------------------------------------------------------------
module bitap_edit_distance_match_test;
  import bedm_pkg::*;

  localparam int PATTERN_BITS   = 256;
  localparam int MAX_ERRORS     = 16;
  localparam int ROWS           = MAX_ERRORS + 1;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int SETTLE_CYCLES  = MAX_ERRORS + 6;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STEP_COUNT     = 28;

  typedef struct packed {
    logic       found;
    logic [4:0] distance;
  } match_result_t;

  typedef enum logic {STEP_ITEM, STEP_CONFIG} step_kind_t;

  typedef struct packed {
    step_kind_t    kind;
    mode_t         mode;
    logic [7:0]    sym;
    logic [7:0]    pos;
    logic [8:0]    len_w;
    logic [8:0]    lim_w;
    logic          fixed;
    match_result_t want;
  } step_t;

  // kind, mode, symbol, position, length, limit, fixed report?, report
  localparam step_t DIRECTED [STEP_COUNT] = '{
    '{STEP_ITEM,   MODE_FINISH,  8'h00,     8'd0,   9'd0,   9'd0,  1'b1, '{1'b1, 5'd1}},
    '{STEP_CONFIG, MODE_CLEAR,   8'h00,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_FINISH,  8'h00,     8'd0,   9'd0,   9'd0,  1'b1, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, CHAR_A,    8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, 8'h58,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, CHAR_C,    8'd1,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    8'h4E,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    CHAR_A_LC, 8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_FINISH,  8'h00,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_CONFIG, MODE_CLEAR,   8'h00,     8'd0,   9'd511, 9'd31, 1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_CLEAR,   8'hFF,     8'd255, 9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_FINISH,  8'hFF,     8'd255, 9'd0,   9'd0,  1'b1, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, CHAR_T,    8'd255, 9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, CHAR_G_LC, 8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    8'h00,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    8'hFF,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    CHAR_T_LC, 8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    CHAR_G,    8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_FINISH,  8'h00,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_CONFIG, MODE_CLEAR,   8'h00,     8'd0,   9'd3,   9'd1,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_CLEAR,   8'h00,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, CHAR_G,    8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, CHAR_A,    8'd1,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_PATTERN, CHAR_T,    8'd2,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    CHAR_T,    8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    CHAR_C_LC, 8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_TEXT,    CHAR_G,    8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}},
    '{STEP_ITEM,   MODE_FINISH,  8'h00,     8'd0,   9'd0,   9'd0,  1'b0, '{1'b0, 5'd0}}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_addr  = REG_PATTERN_LENGTH;
  logic [8:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // symbol[7:0], position[15:8]
  logic [1:0]  s_tuser   = MODE_CLEAR;   // mode[1:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // distance[4:0], zero pad[7:5]
  logic        m_tuser;          // found[0]

  bitap_edit_distance_match #(
    .PATTERN_BITS(PATTERN_BITS),
    .MAX_ERRORS  (MAX_ERRORS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predicted matcher state
  logic [PATTERN_BITS-1:0] base_mask [BASES];
  logic [PATTERN_BITS-1:0] err_row [ROWS];
  logic [8:0]              len_reg;
  logic [4:0]              lim_reg;

  match_result_t reports_due [$];
  int unsigned   mismatches = 0;
  int unsigned   items_done = 0;
  bit            tx_burst   = 1'b0;
  bit            rx_burst   = 1'b0;
  bit            hold_req   = 1'b0;

  function automatic int eff_len();
    if (len_reg < 1) return 1;
    if (len_reg > PATTERN_BITS) return PATTERN_BITS;
    return int'(len_reg);
  endfunction

  function automatic int eff_lim();
    if (lim_reg > MAX_ERRORS) return MAX_ERRORS;
    return int'(lim_reg);
  endfunction

  function automatic int base_index(input logic [7:0] sym);
    case (sym)
      CHAR_A, CHAR_A_LC: return int'(BASE_A);
      CHAR_C, CHAR_C_LC: return int'(BASE_C);
      CHAR_G, CHAR_G_LC: return int'(BASE_G);
      CHAR_T, CHAR_T_LC: return int'(BASE_T);
      default:           return -1;
    endcase
  endfunction

  function automatic void clear_rows();
    int b;
    int d;
    for (b = 0; b < BASES; b++) base_mask[b] = '1;
    for (d = 0; d < ROWS; d++) err_row[d] = {PATTERN_BITS{1'b1}} << d;
  endfunction

  function automatic void advance_rows(input mode_t mode, input logic [7:0] sym,
                                       input logic [7:0] pos, output bit acted,
                                       output bit has_res, output match_result_t res);
    logic [PATTERN_BITS-1:0] prev [ROWS];
    int b;
    int m;
    int k;
    int d;
    b       = base_index(sym);
    m       = eff_len();
    k       = eff_lim();
    acted   = 1'b1;
    has_res = 1'b0;
    res     = '0;
    case (mode)
      MODE_CLEAR: begin
        clear_rows();
      end
      MODE_PATTERN: begin
        if (b >= 0 && int'(pos) < m) base_mask[b][m - 1 - int'(pos)] = 1'b0;
        else acted = 1'b0;
      end
      MODE_TEXT: begin
        if (b < 0) begin
          acted = 1'b0;
        end else begin
          for (d = 0; d < ROWS; d++) prev[d] = err_row[d];
          err_row[0] = (prev[0] << 1) | base_mask[b];
          for (d = 1; d <= k; d++)
            err_row[d] = prev[d-1] & (prev[d-1] << 1) & (err_row[d-1] << 1) &
                         ((prev[d] << 1) | base_mask[b]);
        end
      end
      default: begin
        has_res = 1'b1;
        for (d = 0; d <= k; d++)
          if (!res.found && !err_row[d][m-1]) begin
            res.found    = 1'b1;
            res.distance = 5'(d);
          end
      end
    endcase
  endfunction

  function automatic logic [7:0] random_base();
    case ($urandom_range(0, 7))
      0:       return CHAR_A;
      1:       return CHAR_C;
      2:       return CHAR_G;
      3:       return CHAR_T;
      4:       return CHAR_A_LC;
      5:       return CHAR_C_LC;
      6:       return CHAR_G_LC;
      default: return CHAR_T_LC;
    endcase
  endfunction

  task automatic send_item(input mode_t mode, input logic [7:0] sym, input logic [7:0] pos,
                           input bit fixed = 1'b0, input match_result_t fixed_res = '0);
    int unsigned   gap;
    bit            acted;
    bit            has_res;
    match_result_t res;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {pos, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_rows(mode, sym, pos, acted, has_res, res);
    if (has_res) reports_due.push_back(fixed ? fixed_res : res);
    if (acted) items_done++;
  endtask

  // wait for every report, then for anything still walking the chain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [8:0] len_w, input logic [8:0] lim_w);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PATTERN_LENGTH;
    cfg_wdata <= len_w;
    @(posedge clk);
    cfg_addr  <= REG_ERROR_LIMIT;
    cfg_wdata <= lim_w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_reg = len_w;
    lim_reg = lim_w[4:0];
  endtask

  task automatic pick_config();
    int unsigned r;
    logic [8:0]  len_w;
    logic [4:0]  lim;
    r = $urandom_range(0, 99);
    if (r < 80)      len_w = 9'($urandom_range(1, 16));
    else if (r < 95) len_w = 9'($urandom_range(17, 64));
    else if (r < 98) len_w = 9'($urandom_range(200, 256));
    else if (r < 99) len_w = 9'd0;
    else             len_w = 9'($urandom_range(257, 511));
    r = $urandom_range(0, 99);
    if (r < 70)      lim = 5'($urandom_range(0, 6));
    else if (r < 90) lim = 5'($urandom_range(7, 16));
    else             lim = 5'($urandom_range(17, 31));
    settle();
    write_config(len_w, {4'($urandom_range(0, 15)), lim});
  endtask

  // clear, load a pattern, stream a text that mostly ends on an edited copy of it
  task automatic run_search(input bit new_cfg);
    logic [7:0]  pat [PATTERN_BITS];
    int unsigned m;
    int unsigned i;
    int unsigned p;
    int unsigned r;
    bit          up;
    tx_burst = ($urandom_range(0, 3) == 0);
    if (new_cfg || $urandom_range(0, 9) < 4) pick_config();
    m  = eff_len();
    up = $urandom_range(0, 1);
    send_item(MODE_CLEAR, 8'($urandom), 8'($urandom));
    for (i = 0; i < m; i++) pat[i] = random_base();
    for (i = 0; i < m; i++) begin
      p = up ? i : m - 1 - i;
      if ($urandom_range(0, 19) == 0)
        send_item(MODE_PATTERN, 8'($urandom), 8'($urandom));
      send_item(MODE_PATTERN, pat[p], 8'(p));
    end
    repeat ($urandom_range(0, 4)) send_item(MODE_TEXT, random_base(), 8'($urandom));
    for (i = 0; i < m; i++) begin
      p = m - 1 - i;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(MODE_FINISH, 8'($urandom), 8'($urandom));
        send_item(MODE_TEXT, pat[p], 8'($urandom));
      end else if (r < 10) begin
        send_item(MODE_TEXT, random_base(), 8'($urandom));
        send_item(MODE_TEXT, pat[p], 8'($urandom));
      end else if (r < 15) begin
        send_item(MODE_TEXT, random_base(), 8'($urandom));
      end else if (r < 20) begin
        // deletion: this pattern base never appears in the text
      end else if (r < 23) begin
        send_item(MODE_TEXT, 8'($urandom), 8'($urandom));
        send_item(MODE_TEXT, pat[p], 8'($urandom));
      end else begin
        send_item(MODE_TEXT, pat[p], 8'($urandom));
      end
    end
    send_item(MODE_FINISH, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(MODE_TEXT, random_base(), 8'($urandom));
      send_item(MODE_FINISH, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_noise();
    tx_burst = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(10, 30))
      send_item(mode_t'($urandom_range(0, 3)),
                $urandom_range(0, 1) ? random_base() : 8'($urandom), 8'($urandom));
  endtask

  // receiver holds off while text and finish transfers keep coming
  task automatic run_backlog();
    hold_req = 1'b1;
    tx_burst = 1'b1;
    repeat (40)
      send_item(($urandom_range(0, 2) == 0) ? MODE_FINISH : MODE_TEXT, random_base(),
                8'($urandom));
  endtask

  initial begin : stimulus
    int i;
    bit backlog_done;
    backlog_done = 1'b0;
    len_reg = 9'd1;
    lim_reg = 5'd16;
    clear_rows();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < STEP_COUNT; i++) begin
      if (DIRECTED[i].kind == STEP_CONFIG) begin
        settle();
        write_config(DIRECTED[i].len_w, DIRECTED[i].lim_w);
      end else begin
        send_item(DIRECTED[i].mode, DIRECTED[i].sym, DIRECTED[i].pos,
                  DIRECTED[i].fixed, DIRECTED[i].want);
      end
    end
    items_done = 0;
    run_search(1'b1);
    while (items_done < RANDOM_ITEMS) begin
      if (!backlog_done && items_done > RANDOM_ITEMS / 2) begin
        run_backlog();
        backlog_done = 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        run_noise();
      end else begin
        run_search(1'b0);
      end
    end
    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : report_check
    int unsigned   stall;
    match_result_t want;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: found=%0b distance=%0d", m_tuser, m_tdata);
      end else begin
        want = reports_due.pop_front();
        if (m_tuser !== want.found || m_tdata !== {3'b000, want.distance}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: expected found=%0b distance=%0d, got found=%0b tdata=%0h",
                     want.found, want.distance, m_tuser, m_tdata);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst == 1'b0);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> bitap_edit_distance_match.f
rtl/bedm_pkg.sv
rtl/bedm_mask_store.sv
rtl/bedm_cell.sv
rtl/bitap_edit_distance_match.sv
test/bitap_edit_distance_match_test.sv
